>>> sv/rrj_pkg.sv
// ----------------------------------------------------------------------------
// rrj_pkg
// Types and constants shared by the range residual and Jacobian block.
// ----------------------------------------------------------------------------
package rrj_pkg;

   localparam int MAG_W  = 33;   // magnitude of a delta component
   localparam int SQ_W   = 66;   // square of one magnitude
   localparam int REM_W  = 68;   // square root remainder and trial values
   localparam int ROOT_W = 34;   // square root result
   localparam int QUO_W  = 31;   // quotient bits 30 down to 0
   localparam int SQRT_STAGES = 34;
   localparam int DIV_STAGES  = 31;
   localparam logic [QUO_W-1:0] ONE_Q30 = QUO_W'(1) << 30;

   localparam logic [1:0] REG_POS_X = 2'd0;
   localparam logic [1:0] REG_POS_Y = 2'd1;
   localparam logic [1:0] REG_POS_Z = 2'd2;

   typedef struct packed {
      logic signed [31:0] anchor_x;
      logic signed [31:0] anchor_y;
      logic signed [31:0] anchor_z;
      logic [30:0]        measured_range;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] residual;
      logic signed [31:0] jac_x;
      logic signed [31:0] jac_y;
      logic signed [31:0] jac_z;
      logic               singular;
   } rsp_payload_type;

   typedef struct packed {
      logic                            valid;
      logic [2:0][MAG_W-1:0]           mag;
      logic [2:0]                      neg;
      logic [30:0]                     meas;
   } delta_stage_type;

   typedef struct packed {
      logic                            valid;
      logic [2:0][SQ_W-1:0]            sq;
      logic [2:0][MAG_W-1:0]           mag;
      logic [2:0]                      neg;
      logic [30:0]                     meas;
   } square_stage_type;

   typedef struct packed {
      logic                            valid;
      logic [REM_W-1:0]                rem;
      logic [ROOT_W-1:0]               root;
      logic [2:0][MAG_W-1:0]           mag;
      logic [2:0]                      neg;
      logic [30:0]                     meas;
   } sqrt_stage_type;

   typedef struct packed {
      logic                            valid;
      logic [ROOT_W-1:0]               distance;
      logic [2:0][ROOT_W-1:0]          r;
      logic [2:0][QUO_W-1:0]           q;
      logic [2:0]                      neg;
      logic [30:0]                     meas;
   } div_stage_type;

endpackage

>>> sv/range_residual_and_jacobian.sv
// ----------------------------------------------------------------------------
// range_residual_and_jacobian
// Range residual and unit direction row for one anchor measurement.
// ----------------------------------------------------------------------------
// Each item on the req_ channel carries an anchor position and a measured
// range. The block subtracts the anchor from the position held in the csr_
// registers, squares and sums the components, takes a pipelined square root
// (one result bit per stage) and divides each component magnitude by the
// distance in three pipelined dividers (one quotient bit per stage).
// The rsp_ channel returns the saturated residual, the Q1.30 direction and a
// singular flag that is set when the position equals the anchor.
//
// Throughput is one item per cycle while the receiver takes results. The path
// has 70 register stages: 3 for delta, squares and sum, 34 square root
// stages, one register ahead of the dividers, 31 divider stages and the
// output register. Reset clears all valid bits and the position registers.
// When the receiver stalls, the whole pipeline holds and req_ready drops;
// a stalled output keeps its item until it is taken.
// ----------------------------------------------------------------------------
module range_residual_and_jacobian
   import rrj_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [3:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);

   logic [31:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic        advance;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            REG_POS_X: pos_x_ff <= pwdata;
            REG_POS_Y: pos_y_ff <= pwdata;
            REG_POS_Z: pos_z_ff <= pwdata;
            default:   ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_POS_X: prdata = pos_x_ff;
         REG_POS_Y: prdata = pos_y_ff;
         REG_POS_Z: prdata = pos_z_ff;
         default:   prdata = '0;
      endcase
   end

   // The pipeline moves as one; it holds only while a result waits.
   assign advance   = !(rsp_valid && !rsp_ready);
   assign req_ready = advance;

   // Stage 1: deltas and magnitudes.
   delta_stage_type d_ff, d_in;
   logic [2:0][31:0] pos_v, anc_v;

   always_comb begin
      logic signed [MAG_W-1:0] dl;
      pos_v = {pos_x_ff, pos_y_ff, pos_z_ff};
      anc_v = {req_data.anchor_x, req_data.anchor_y, req_data.anchor_z};
      d_in.valid = req_valid;
      d_in.meas  = req_data.measured_range;
      for (int i = 0; i < 3; i++) begin
         dl = {pos_v[i][31], pos_v[i]} - {anc_v[i][31], anc_v[i]};
         d_in.neg[i] = dl[MAG_W-1];
         d_in.mag[i] = dl[MAG_W-1] ? MAG_W'(-dl) : MAG_W'(dl);
      end
   end

   // Stage 2: squares.
   square_stage_type s_ff, s_in;

   always_comb begin
      s_in.valid = d_ff.valid;
      s_in.mag   = d_ff.mag;
      s_in.neg   = d_ff.neg;
      s_in.meas  = d_ff.meas;
      for (int i = 0; i < 3; i++) begin
         s_in.sq[i] = SQ_W'(d_ff.mag[i]) * SQ_W'(d_ff.mag[i]);
      end
   end

   // Stage 3 feeds the square root chain with the sum of squares.
   sqrt_stage_type sq_ff [SQRT_STAGES+1];
   sqrt_stage_type sq_in [SQRT_STAGES+1];

   always_comb begin
      sq_in[0].valid = s_ff.valid;
      sq_in[0].rem   = REM_W'(s_ff.sq[0]) + REM_W'(s_ff.sq[1]) + REM_W'(s_ff.sq[2]);
      sq_in[0].root  = '0;
      sq_in[0].mag   = s_ff.mag;
      sq_in[0].neg   = s_ff.neg;
      sq_in[0].meas  = s_ff.meas;
   end

   // Each stage decides one root bit, keeping rem = sum - root^2.
   for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
      localparam int B = SQRT_STAGES - 1 - i;
      always_comb begin
         logic [REM_W-1:0] trial;
         trial = (REM_W'(sq_ff[i].root) << (B + 1)) + (REM_W'(1) << (2 * B));
         sq_in[i+1] = sq_ff[i];
         if (sq_ff[i].rem >= trial) begin
            sq_in[i+1].rem  = sq_ff[i].rem - trial;
            sq_in[i+1].root = sq_ff[i].root | (ROOT_W'(1) << B);
         end
      end
   end

   div_stage_type dv_ff [DIV_STAGES+1];
   div_stage_type dv_in [DIV_STAGES+1];

   always_comb begin
      dv_in[0].valid    = sq_ff[SQRT_STAGES].valid;
      dv_in[0].distance = sq_ff[SQRT_STAGES].root;
      dv_in[0].neg      = sq_ff[SQRT_STAGES].neg;
      dv_in[0].meas     = sq_ff[SQRT_STAGES].meas;
      dv_in[0].q        = '0;
      for (int c = 0; c < 3; c++) begin
         dv_in[0].r[c] = ROOT_W'(sq_ff[SQRT_STAGES].mag[c]);
      end
   end

   // Long division of mag * 2^30 by the distance; the magnitude never
   // exceeds the distance, so the remainder fits the distance width.
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      localparam int K = DIV_STAGES - 1 - j;
      always_comb begin
         logic [ROOT_W-1:0] rr;
         dv_in[j+1] = dv_ff[j];
         for (int c = 0; c < 3; c++) begin
            rr = dv_ff[j].r[c];
            if (rr >= dv_ff[j].distance) begin
               rr = rr - dv_ff[j].distance;
               dv_in[j+1].q[c][K] = 1'b1;
            end
            dv_in[j+1].r[c] = rr << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff <= '0;
         s_ff <= '0;
         for (int i = 0; i <= SQRT_STAGES; i++) sq_ff[i] <= '0;
         for (int j = 0; j <= DIV_STAGES; j++) dv_ff[j] <= '0;
      end else if (advance) begin
         d_ff <= d_in;
         s_ff <= s_in;
         sq_ff[0] <= sq_in[0];
         for (int i = 0; i < SQRT_STAGES; i++) sq_ff[i+1] <= sq_in[i+1];
         dv_ff[0] <= dv_in[0];
         for (int j = 0; j < DIV_STAGES; j++) dv_ff[j+1] <= dv_in[j+1];
      end
   end

   // Output stage: residual saturation, sign and clamp of the direction, singular flag.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   always_comb begin
      div_stage_type    t;
      logic signed [35:0] res;
      logic [QUO_W-1:0] qc;
      logic [2:0][31:0] jac;
      t = dv_ff[DIV_STAGES];
      rsp_valid_in = t.valid;
      res = $signed({2'b00, t.distance}) - $signed({5'b00000, t.meas});
      if (res > 36'sh0_7FFF_FFFF)
         rsp_data_in.residual = 32'h7FFF_FFFF;
      else if (res < -36'sh0_8000_0000)
         rsp_data_in.residual = 32'h8000_0000;
      else
         rsp_data_in.residual = res[31:0];
      for (int c = 0; c < 3; c++) begin
         qc = (t.q[c] > ONE_Q30) ? ONE_Q30 : t.q[c];
         jac[c] = t.neg[c] ? -{1'b0, qc} : {1'b0, qc};
         if (t.distance == '0) jac[c] = '0;
      end
      // Lane 2 carries x and lane 0 carries z, as packed in stage 1.
      rsp_data_in.jac_x    = jac[2];
      rsp_data_in.jac_y    = jac[1];
      rsp_data_in.jac_z    = jac[0];
      rsp_data_in.singular = (t.distance == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |->
         rsp_data.jac_x == '0 && rsp_data.jac_y == '0 && rsp_data.jac_z == '0)
      else $error("singular result with nonzero direction");

   a_jac_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_data.jac_x) <= 32'sh4000_0000 &&
                    $signed(rsp_data.jac_x) >= -32'sh4000_0000)
      else $error("direction component out of unit range");

   a_stall_only_on_wait: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a waiting result");

   a_residual_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_data.residual) > -32'sh7FFF_FFFF - 32'sd1)
      else $error("residual below the smallest possible value");

endmodule
